>>> design/rtumf_pkg.sv
`default_nettype none

package rtumf_pkg;

    localparam int MAX_TARGETS = 4096;
    localparam int MAX_MATCHES = 4096;
    localparam int TGT_AW      = $clog2(MAX_TARGETS);
    localparam int MATCH_AW    = $clog2(MAX_MATCHES);
    localparam int CNT_W       = MATCH_AW + 1;
    localparam int CLR_W       = TGT_AW + 1;
    localparam int TBL_W       = MATCH_AW + 1;
    localparam int STORE_W     = 56;
    localparam int SUB_W       = 33;
    localparam int DIV_STEPS   = 32;
    localparam int SQRT_STEPS  = 16;
    localparam int STEP_W      = 5;

    localparam logic [1:0] REG_RATIO_MODE   = 2'd0;
    localparam logic [1:0] REG_RATIO_THRESH = 2'd1;
    localparam logic [1:0] REG_ONLY_UNIQUES = 2'd2;

    typedef enum logic [1:0] {
        OP_BEGIN = 2'd0,
        OP_PUSH  = 2'd1,
        OP_READ  = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MUL1,
        ST_MUL2,
        ST_TEST,
        ST_DIV,
        ST_SQRT,
        ST_WRITE,
        ST_FLAG2,
        ST_RD_WAIT,
        ST_RD_DATA,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic        acc;
        logic [11:0] qi;
        logic [11:0] to;
        logic [31:0] score;
        logic        un;
        logic [12:0] mc;
    } t_result;

    typedef struct packed {
        logic [SUB_W-1:0] a;
        logic [SUB_W-1:0] b;
    } t_sub_req;

    typedef struct packed {
        logic [SUB_W-1:0] diff;
        logic             ge;
    } t_sub_rsp;

endpackage

`default_nettype wire

>>> design/rtumf_ram.sv
`default_nettype none

module rtumf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

>>> design/rtumf_sub.sv
`default_nettype none

module rtumf_sub (
    input  wire rtumf_pkg::t_sub_req i_req,
    output rtumf_pkg::t_sub_rsp      o_rsp
);
    import rtumf_pkg::*;

    logic [SUB_W:0] w_full;

    // one extra bit gives the borrow: clear borrow means a >= b
    assign w_full     = {1'b0, i_req.a} - {1'b0, i_req.b};
    assign o_rsp.diff = w_full[SUB_W-1:0];
    assign o_rsp.ge   = ~w_full[SUB_W];

endmodule

`default_nettype wire

>>> design/ratio_test_unique_match_filter_unit.sv
// Ratio test and unique match filter, one transaction at a time on a shared compare-subtract unit.
// A kept ratio push runs 32 divide and then 16 square root steps before its result; begin sweeps the
// target table one entry a cycle. The next input is accepted only after the previous result has
// been loaded into the output register.
// Reset (synchronous, active low) runs the same table sweep; no input is accepted until it
// finishes, configuration writes are taken throughout.
`default_nettype none

module ratio_test_unique_match_filter_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // slave side
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // tdata: target_index[11:0], dist_first[43:12], dist_second[75:44],
    //        entry_index[87:76]
    input  wire logic [87:0] s_axis_tdata,
    // tuser: op[1:0]
    input  wire logic [1:0]  s_axis_tuser,
    // master side
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // tdata: query_index[11:0], target_index_out[23:12], score[55:24],
    //        match_count[68:56], zero fill[71:69]
    output logic      [71:0] m_axis_tdata,
    // tuser: accepted[0], unique_res[1]
    output logic      [1:0]  m_axis_tuser,
    // configuration write port
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_addr,
    input  wire logic [15:0] i_cfg_wdata
);
    import rtumf_pkg::*;

    // configuration
    logic        r_ratio_mode;
    logic [15:0] r_thresh;
    logic        r_only_uniques;

    // control
    t_state           r_state, n_state;
    logic [CLR_W-1:0] r_clr;
    logic             r_pend;
    logic [STEP_W-1:0] r_cnt;
    logic [CNT_W-1:0] r_kept;
    logic [12:0]      r_nq;

    // captured transaction
    logic [11:0] r_tgt;
    logic [31:0] r_d0;
    logic [31:0] r_d1;
    logic [11:0] r_ent;
    logic [11:0] r_q;

    // arithmetic
    logic [31:0] r_tt;
    logic [63:0] r_prod;
    logic [31:0] r_rem;
    logic [31:0] r_quo;
    logic [15:0] r_root;

    // result staging and output
    t_result r_res;
    t_result r_out;
    logic    r_out_valid;

    // memory ports
    logic                tbl_we;
    logic [TGT_AW-1:0]   tbl_waddr;
    logic [TBL_W-1:0]    tbl_wdata;
    logic [TBL_W-1:0]    tbl_rdata;
    logic                ms_we;
    logic [MATCH_AW-1:0] ms_waddr;
    logic [STORE_W-1:0]  ms_wdata;
    logic [STORE_W-1:0]  ms_rdata;
    logic                fl_we;
    logic [MATCH_AW-1:0] fl_waddr;
    logic                fl_wdata;
    logic                fl_rdata;

    t_sub_req sub_req;
    t_sub_rsp sub_rsp;

    logic          in_acc;
    t_op           in_op;
    logic          tbl_hit;
    logic          keep;
    logic          ratio_ok;
    logic          rd_hit;
    logic [31:0]   score_w;

    assign in_op   = t_op'(s_axis_tuser);
    assign in_acc  = s_axis_tvalid && s_axis_tready;
    assign tbl_hit = tbl_rdata[TBL_W-1];

    // ratio test done exactly: d0 * 2^32 < thresh^2 * d1, d1 of zero fails
    assign ratio_ok = (r_d1 != 32'd0) && ({r_d0, 32'd0} < r_prod);
    assign keep = (r_ratio_mode ? ratio_ok : 1'b1)
                && ({1'b0, r_tgt} < 13'(MAX_TARGETS))
                && (r_kept < CNT_W'(MAX_MATCHES));
    assign rd_hit  = {1'b0, r_ent} < r_kept;
    assign score_w = r_ratio_mode ? {16'd0, r_root} : r_d0;

    // ---------------------------------------------------------------------
    // Memories: target table holds {valid, first kept index} per target
    // ---------------------------------------------------------------------
    rtumf_ram #(.WIDTH(TBL_W), .DEPTH(MAX_TARGETS)) u_tbl (
        .i_clk   (i_clk),
        .i_we    (tbl_we),
        .i_waddr (tbl_waddr),
        .i_wdata (tbl_wdata),
        .i_raddr (TGT_AW'(r_tgt)),
        .o_rdata (tbl_rdata)
    );

    rtumf_ram #(.WIDTH(STORE_W), .DEPTH(MAX_MATCHES)) u_store (
        .i_clk   (i_clk),
        .i_we    (ms_we),
        .i_waddr (ms_waddr),
        .i_wdata (ms_wdata),
        .i_raddr (MATCH_AW'(r_ent)),
        .o_rdata (ms_rdata)
    );

    rtumf_ram #(.WIDTH(1), .DEPTH(MAX_MATCHES)) u_flags (
        .i_clk   (i_clk),
        .i_we    (fl_we),
        .i_waddr (fl_waddr),
        .i_wdata (fl_wdata),
        .i_raddr (MATCH_AW'(r_ent)),
        .o_rdata (fl_rdata)
    );

    rtumf_sub u_sub (
        .i_req (sub_req),
        .o_rsp (sub_rsp)
    );

    // ---------------------------------------------------------------------
    // Next state
    // ---------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (r_clr == CLR_W'(MAX_TARGETS - 1)) begin
                    n_state = r_pend ? ST_DONE : ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (in_acc) begin
                    unique case (in_op)
                        OP_BEGIN: n_state = ST_CLEAR;
                        OP_PUSH:  n_state = ST_MUL1;
                        OP_READ:  n_state = ST_RD_WAIT;
                        OP_NONE:  n_state = ST_DONE;
                    endcase
                end
            end
            ST_MUL1: n_state = ST_MUL2;
            ST_MUL2: n_state = ST_TEST;
            ST_TEST: begin
                priority if (!keep) begin
                    n_state = ST_DONE;
                end else if (r_ratio_mode) begin
                    n_state = ST_DIV;
                end else begin
                    n_state = ST_WRITE;
                end
            end
            ST_DIV: begin
                if (r_cnt == STEP_W'(DIV_STEPS - 1)) begin
                    n_state = ST_SQRT;
                end
            end
            ST_SQRT: begin
                if (r_cnt == STEP_W'(SQRT_STEPS - 1)) begin
                    n_state = ST_WRITE;
                end
            end
            ST_WRITE:   n_state = tbl_hit ? ST_FLAG2 : ST_DONE;
            ST_FLAG2:   n_state = ST_DONE;
            ST_RD_WAIT: n_state = ST_RD_DATA;
            ST_RD_DATA: n_state = ST_DONE;
            ST_DONE: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // ---------------------------------------------------------------------
    // Outputs of the sequencer: handshake, memory writes, shared unit
    // ---------------------------------------------------------------------
    always_comb begin
        s_axis_tready = (r_state == ST_IDLE);
        tbl_we    = 1'b0;
        tbl_waddr = TGT_AW'(r_tgt);
        tbl_wdata = {1'b1, MATCH_AW'(r_kept)};
        ms_we     = 1'b0;
        ms_waddr  = MATCH_AW'(r_kept);
        ms_wdata  = {score_w, r_tgt, r_q};
        fl_we     = 1'b0;
        fl_waddr  = MATCH_AW'(r_kept);
        fl_wdata  = ~tbl_hit;
        sub_req.a = {r_rem, 1'b0};
        sub_req.b = {1'b0, r_d1};
        unique case (r_state)
            ST_CLEAR: begin
                tbl_we    = 1'b1;
                tbl_waddr = r_clr[TGT_AW-1:0];
                tbl_wdata = '0;
            end
            ST_SQRT: begin
                // remainder takes the next two radicand bits, trial is 4*root+1
                sub_req.a = {r_rem[30:0], r_quo[31:30]};
                sub_req.b = {15'd0, r_root, 2'b01};
            end
            ST_WRITE: begin
                ms_we  = 1'b1;
                fl_we  = 1'b1;
                tbl_we = ~tbl_hit;
            end
            ST_FLAG2: begin
                // earlier match on the same target loses its flag too
                fl_we    = 1'b1;
                fl_waddr = tbl_rdata[MATCH_AW-1:0];
                fl_wdata = 1'b0;
            end
            default: begin
            end
        endcase
    end

    // ---------------------------------------------------------------------
    // Registers
    // ---------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ratio_mode   <= 1'b1;
            r_thresh       <= 16'd52429;
            r_only_uniques <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                REG_RATIO_MODE:   r_ratio_mode   <= i_cfg_wdata[0];
                REG_RATIO_THRESH: r_thresh       <= i_cfg_wdata;
                REG_ONLY_UNIQUES: r_only_uniques <= i_cfg_wdata[0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_clr   <= '0;
            r_pend  <= 1'b0;
            r_kept  <= '0;
            r_nq    <= '0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            unique case (r_state)
                ST_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                end
                ST_IDLE: begin
                    if (in_acc) begin
                        r_cnt <= '0;
                        unique case (in_op)
                            OP_BEGIN: begin
                                r_clr  <= '0;
                                r_pend <= 1'b1;
                                r_kept <= '0;
                                r_nq   <= '0;
                            end
                            OP_PUSH:  r_nq <= r_nq + 1'b1;
                            OP_READ, OP_NONE: begin
                            end
                        endcase
                    end
                end
                ST_DIV, ST_SQRT: begin
                    r_cnt <= (n_state == r_state) ? r_cnt + 1'b1 : '0;
                end
                ST_WRITE: begin
                    r_kept <= r_kept + 1'b1;
                end
                ST_DONE: begin
                    r_pend <= 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

    // datapath: no reset needed
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    r_tgt <= s_axis_tdata[11:0];
                    r_d0  <= s_axis_tdata[43:12];
                    r_d1  <= s_axis_tdata[75:44];
                    r_ent <= s_axis_tdata[87:76];
                    r_q   <= r_nq[11:0];
                    // begin reports an empty set, the others the current count
                    r_res <= '{acc: (in_op == OP_BEGIN), qi: 12'd0, to: 12'd0,
                               score: 32'd0, un: 1'b0,
                               mc: (in_op == OP_BEGIN) ? 13'd0 : r_kept};
                end
            end
            ST_MUL1: r_tt   <= 32'(r_thresh) * 32'(r_thresh);
            ST_MUL2: r_prod <= 64'(r_tt) * 64'(r_d1);
            ST_TEST: begin
                // rejected push still reports its query and target
                r_res <= '{acc: 1'b0, qi: r_q, to: r_tgt, score: 32'd0, un: 1'b0,
                           mc: r_kept};
                r_rem <= r_d0;
                r_quo <= '0;
            end
            ST_DIV: begin
                // restoring divide of d0 * 2^32 by d1, one quotient bit a step
                r_quo <= {r_quo[30:0], sub_rsp.ge};
                if (r_cnt == STEP_W'(DIV_STEPS - 1)) begin
                    r_rem  <= '0;
                    r_root <= '0;
                end else begin
                    r_rem <= sub_rsp.ge ? sub_rsp.diff[31:0] : sub_req.a[31:0];
                end
            end
            ST_SQRT: begin
                // digit recurrence square root, one root bit a step
                r_rem  <= sub_rsp.ge ? sub_rsp.diff[31:0] : sub_req.a[31:0];
                r_root <= {r_root[14:0], sub_rsp.ge};
                r_quo  <= {r_quo[29:0], 2'b00};
            end
            ST_WRITE: begin
                r_res <= '{acc: 1'b1, qi: r_q, to: r_tgt, score: score_w,
                           un: r_only_uniques ? ~tbl_hit : 1'b1,
                           mc: r_kept + 13'd1};
            end
            ST_RD_DATA: begin
                if (rd_hit) begin
                    r_res <= '{acc: 1'b1, qi: ms_rdata[11:0], to: ms_rdata[23:12],
                               score: ms_rdata[55:24],
                               un: r_only_uniques ? fl_rdata : 1'b1,
                               mc: r_kept};
                end else begin
                    r_res <= '{acc: 1'b0, qi: 12'd0, to: 12'd0, score: 32'd0, un: 1'b0,
                               mc: r_kept};
                end
            end
            default: begin
            end
        endcase
    end

    // output register: hold until the transaction completes downstream
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == ST_DONE && (!r_out_valid || m_axis_tready)) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_DONE && (!r_out_valid || m_axis_tready)) begin
            r_out <= r_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {3'b000, r_out.mc, r_out.score, r_out.to, r_out.qi};
    assign m_axis_tuser  = {r_out.un, r_out.acc};

`ifndef SYNTHESIS
    // a unique flag is only ever reported on an existing match
    a_unique_needs_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[1]) |-> m_axis_tuser[0])
        else $error("unique flag on a result that was not accepted");

    // a rejected push or a missed read carries no score
    a_reject_no_score: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata[55:24] == 32'd0))
        else $error("score reported on a rejected result");

    // the kept count never runs past the store depth
    a_kept_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_kept <= CNT_W'(MAX_MATCHES)))
        else $error("kept count beyond store depth");

    // a begin leaves the set empty once the sweep has started
    a_begin_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && in_op == OP_BEGIN) |=> (r_kept == '0 && r_state == ST_CLEAR))
        else $error("begin did not start the table sweep");
`endif

endmodule

`default_nettype wire
